[rtl/core/cpra_pkg.sv]
`timescale 1ns / 1ps

package cpra_pkg;

   localparam int ENTRIES     = 1024;
   localparam int REGIONS     = 12;
   localparam int PAGE_SHIFT  = 12;

   localparam int TOTAL_PAGES = REGIONS * ENTRIES;
   localparam int PAGE_W      = $clog2(TOTAL_PAGES + 1);
   localparam int WORD_W      = 32;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int NUM_WORDS   = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
   localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int LAST_BITS   = TOTAL_PAGES - (NUM_WORDS - 1) * WORD_W;

   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
   localparam logic [WORD_W-1:0]  LAST_MASK = WORD_W'((64'd1 << LAST_BITS) - 64'd1);
   localparam logic [31:0]        VBASE_PAGES = 32'(5 * ENTRIES);
   localparam logic [31:0]        PAGE_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

   localparam int BYTES_W = 32;
   localparam int INDEX_W = 14;
   localparam int TAKEN_W = 14;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic                we;
      logic [WADDR_W-1:0]  waddr;
      logic [WORD_W-1:0]   wdata;
      logic                re;
      logic [WADDR_W-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic                status;
      logic [BYTES_W-1:0]  start_address;
      logic [TAKEN_W-1:0]  pages_taken;
   } rsp_type;

endpackage

[rtl/core/cpra_map_ram.sv]
`timescale 1ns / 1ps

module cpra_map_ram
   import cpra_pkg::*;
(
   input  logic               clock,
   input  ram_req_type        ram_req,
   output logic [WORD_W-1:0]  ram_rdata
);

   logic [WORD_W-1:0] mem [NUM_WORDS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

[rtl/core/cpra_engine.sv]
`timescale 1ns / 1ps

module cpra_engine
   import cpra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [BYTES_W-1:0]  req_byte_count,
   input  logic [INDEX_W-1:0]  req_page_index,
   input  logic                req_free_value,
   output ram_req_type         ram_req,
   input  logic [WORD_W-1:0]   ram_rdata,
   output logic                res_valid,
   input  logic                res_ready,
   output rsp_type             res
);

   localparam int CHUNK_W  = WORD_W / 2;
   localparam int CHUNK_AW = $clog2(CHUNK_W);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_BIT, ST_SCAN_LO, ST_SCAN_HI, ST_CLR_RD, ST_CLR_WR, ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [WADDR_W-1:0]  init_w_ff, init_w_in;
   logic [WADDR_W-1:0]  word_ff, word_in;
   logic [PAGE_W-1:0]   need_ff, need_in;
   logic [PAGE_W-1:0]   run_ff, run_in;
   logic [PAGE_W-1:0]   start_ff, start_in;
   logic [PAGE_W-1:0]   end_ff, end_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic                free_ff, free_in;
   rsp_type             res_ff, res_in;

   // chunk scan
   logic [CHUNK_W-1:0]  chunk;
   logic                seen_zero;
   logic [CHUNK_AW-1:0] zpos;
   logic [PAGE_W:0]     run_pos [CHUNK_W];
   logic                hit;
   logic [CHUNK_AW-1:0] hit_pos;
   logic [PAGE_W-1:0]   hit_page;
   logic [PAGE_W-1:0]   hit_start;

   always_comb begin
      chunk = (state_ff == ST_SCAN_HI) ? ram_rdata[WORD_W-1:CHUNK_W] : ram_rdata[CHUNK_W-1:0];
      seen_zero = 1'b0;
      zpos = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
         if (!chunk[b]) begin
            seen_zero = 1'b1;
            zpos = CHUNK_AW'(b);
         end
         run_pos[b] = seen_zero ? (PAGE_W+1)'(CHUNK_AW'(b) - zpos)
                                : (PAGE_W+1)'(run_ff) + (PAGE_W+1)'(b + 1);
      end
      hit = 1'b0;
      hit_pos = '0;
      for (int b = CHUNK_W - 1; b >= 0; b--) begin
         if (run_pos[b] >= {1'b0, need_ff}) begin
            hit = 1'b1;
            hit_pos = CHUNK_AW'(b);
         end
      end
      hit_page = PAGE_W'({word_ff, (state_ff == ST_SCAN_HI), hit_pos});
      hit_start = hit_page + PAGE_W'(1) - need_ff;
   end

   // clear mask for the current word of the run
   logic [WADDR_W-1:0] start_word;
   logic [WADDR_W-1:0] end_word;
   logic [BIT_W-1:0]   clr_lo;
   logic [BIT_W-1:0]   clr_hi;
   logic [WORD_W-1:0]  clr_data;

   always_comb begin
      start_word = WADDR_W'(start_ff >> BIT_W);
      end_word   = WADDR_W'(end_ff >> BIT_W);
      clr_lo = (word_ff == start_word) ? start_ff[BIT_W-1:0] : '0;
      clr_hi = (word_ff == end_word) ? end_ff[BIT_W-1:0] : '1;
      for (int k = 0; k < WORD_W; k++) begin
         clr_data[k] = ram_rdata[k] & !((BIT_W'(k) >= clr_lo) && (BIT_W'(k) <= clr_hi));
      end
   end

   logic [31:0] need_bytes;

   always_comb begin
      need_bytes = (req_byte_count >> PAGE_SHIFT) + 32'(|(req_byte_count & PAGE_MASK));

      state_in  = state_ff;
      init_w_in = init_w_ff;
      word_in   = word_ff;
      need_in   = need_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      bit_in    = bit_ff;
      free_in   = free_ff;
      res_in    = res_ff;
      ram_req   = '0;

      case (state_ff)
         ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = init_w_ff;
            ram_req.wdata = (init_w_ff == LAST_WORD) ? LAST_MASK : '1;
            init_w_in = init_w_ff + WADDR_W'(1);
            if (init_w_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '{STATUS_FAIL, '0, '0};
               if (req_command == CMD_WRITE) begin
                  if (32'(req_page_index) >= 32'(TOTAL_PAGES)) begin
                     state_in = ST_DONE;
                  end else begin
                     ram_req.re    = 1'b1;
                     ram_req.raddr = WADDR_W'(req_page_index >> BIT_W);
                     word_in  = WADDR_W'(req_page_index >> BIT_W);
                     bit_in   = req_page_index[BIT_W-1:0];
                     free_in  = req_free_value;
                     state_in = ST_BIT;
                  end
               end else if (need_bytes == 32'd0 || need_bytes > 32'(TOTAL_PAGES)) begin
                  state_in = ST_DONE;
               end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = '0;
                  word_in  = '0;
                  run_in   = '0;
                  need_in  = PAGE_W'(need_bytes);
                  state_in = ST_SCAN_LO;
               end
            end
         end
         ST_BIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = word_ff;
            ram_req.wdata = (ram_rdata & ~(WORD_W'(1) << bit_ff)) |
                            (WORD_W'(free_ff) << bit_ff);
            res_in   = '{STATUS_OK, '0, '0};
            state_in = ST_DONE;
         end
         ST_SCAN_LO, ST_SCAN_HI: begin
            if (hit) begin
               start_in = hit_start;
               end_in   = hit_page;
               word_in  = WADDR_W'(hit_start >> BIT_W);
               state_in = ST_CLR_RD;
            end else begin
               run_in = PAGE_W'(run_pos[CHUNK_W-1]);
               if (state_ff == ST_SCAN_LO) begin
                  state_in = ST_SCAN_HI;
               end else if (word_ff == LAST_WORD) begin
                  state_in = ST_DONE;
               end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = word_ff + WADDR_W'(1);
                  word_in  = word_ff + WADDR_W'(1);
                  state_in = ST_SCAN_LO;
               end
            end
         end
         ST_CLR_RD: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = word_ff;
            state_in = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = word_ff;
            ram_req.wdata = clr_data;
            if (word_ff == end_word) begin
               res_in.status        = STATUS_OK;
               res_in.start_address = (32'(start_ff) + VBASE_PAGES) << PAGE_SHIFT;
               res_in.pages_taken   = TAKEN_W'(need_ff);
               state_in = ST_DONE;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = word_ff + WADDR_W'(1);
               word_in = word_ff + WADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         init_w_ff <= '0;
      end else begin
         state_ff  <= state_in;
         init_w_ff <= init_w_in;
      end
      word_ff  <= word_in;
      need_ff  <= need_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      bit_ff   <= bit_in;
      free_ff  <= free_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

`ifndef SYNTH
   a_no_same_word_rw: assert property (@(posedge clock) disable iff (reset)
      ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
      else $error("read and write of the same map word in one cycle");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_req.we)
      else $error("map written while idle");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == STATUS_FAIL |->
         res.start_address == '0 && res.pages_taken == '0)
      else $error("failed request carries address or page count");

   a_clear_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLR_WR |-> word_ff >= start_word && word_ff <= end_word)
      else $error("clear outside of allocated run");

   a_scan_need: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_LO |-> need_ff != '0 && run_ff < need_ff)
      else $error("scan with bad run length");
`endif

endmodule

[rtl/core/contiguous_page_run_allocator.sv]
`timescale 1ns / 1ps

// First-fit allocator of contiguous page runs over a free-page bitmap held in a
// single 32-bit-wide synchronous RAM (one bit per page, 1 = free). After reset the
// map is filled with all pages free, one word per cycle, and no request is taken
// during that pass. A bit write request reads the map word, modifies the bit and
// writes it back. An allocate request scans the map from page 0, 16 pages per cycle,
// up to the word holding the last page of the first fitting run, then reads and
// clears the run at one word per cycle. A request that finds no fitting run scans
// the whole map; a zero-length or oversize request fails without a scan. One request
// is in flight at a time; the response sits in an output register, so the next
// request can enter while it waits.
module contiguous_page_run_allocator
   import cpra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [BYTES_W-1:0]  req_byte_count,
   input  logic [INDEX_W-1:0]  req_page_index,
   input  logic                req_free_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status,
   output logic [BYTES_W-1:0]  rsp_start_address,
   output logic [TAKEN_W-1:0]  rsp_pages_taken
);

   ram_req_type        ram_req;
   logic [WORD_W-1:0]  ram_rdata;
   logic               res_valid;
   logic               res_ready;
   rsp_type            res;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   cpra_map_ram u_map_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   cpra_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_byte_count (req_byte_count),
      .req_page_index (req_page_index),
      .req_free_value (req_free_value),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res)
   );

   // output slot
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_start_address = rsp_ff.start_address;
   assign rsp_pages_taken   = rsp_ff.pages_taken;

endmodule

[tb/sv/page_run_checker.sv]
`timescale 1ns / 1ps

module page_run_checker
   import cpra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_command,
   input  logic [BYTES_W-1:0]  req_byte_count,
   input  logic [INDEX_W-1:0]  req_page_index,
   input  logic                req_free_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_status,
   input  logic [BYTES_W-1:0]  rsp_start_address,
   input  logic [TAKEN_W-1:0]  rsp_pages_taken,
   output int                  mismatches,
   output int                  pending,
   output int                  runs_granted
);

   logic    page_free [TOTAL_PAGES];
   rsp_type due_responses [$];
   rsp_type oldest;
   int      responses;

   // first-fit run search over the free map, updates the map as the block would
   function automatic rsp_type apply_page_request(input logic                cmd,
                                                  input logic [BYTES_W-1:0]  bytes,
                                                  input logic [INDEX_W-1:0]  idx,
                                                  input logic                fv);
      rsp_type     r;
      int unsigned need;
      int unsigned run;
      int unsigned first;
      int unsigned p;
      bit          hit;
      r = '0;
      r.status = STATUS_FAIL;
      if (cmd == CMD_WRITE) begin
         if (int'(idx) < TOTAL_PAGES) begin
            page_free[idx] = fv;
            r.status = STATUS_OK;
         end
         return r;
      end
      need = (bytes >> PAGE_SHIFT) + ((bytes & PAGE_MASK) != '0);
      if (need == 0 || need > TOTAL_PAGES) return r;
      run   = 0;
      first = 0;
      hit   = 1'b0;
      for (p = 0; p < TOTAL_PAGES && !hit; p++) begin
         if (page_free[p]) begin
            if (run == 0) first = p;
            run++;
            if (run == need) hit = 1'b1;
         end else begin
            run = 0;
         end
      end
      if (!hit) return r;
      for (p = first; p < first + need; p++) page_free[p] = 1'b0;
      r.status        = STATUS_OK;
      r.start_address = BYTES_W'((first + VBASE_PAGES) << PAGE_SHIFT);
      r.pages_taken   = TAKEN_W'(need);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t response %0d: %s expected 0x%0h, got 0x%0h",
                     $time, responses, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < TOTAL_PAGES; p++) page_free[p] = 1'b1;
         due_responses.delete();
         mismatches   = 0;
         pending      = 0;
         runs_granted = 0;
         responses    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t response %0d arrived with no request outstanding",
                           $time, responses);
               end
            end else begin
               oldest = due_responses.pop_front();
               check_field("status", 32'(oldest.status), 32'(rsp_status));
               check_field("start_address", oldest.start_address, rsp_start_address);
               check_field("pages_taken", 32'(oldest.pages_taken), 32'(rsp_pages_taken));
               if (oldest.pages_taken != '0) runs_granted++;
            end
            responses++;
         end
         if (req_valid && req_ready) begin
            due_responses.push_back(apply_page_request(req_command, req_byte_count,
                                                       req_page_index, req_free_value));
         end
         pending = due_responses.size();
      end
   end

endmodule

[tb/sv/tb_contiguous_page_run_allocator.sv]
`timescale 1ns / 1ps

module tb_contiguous_page_run_allocator;
   import cpra_pkg::*;

   localparam int RANDOM_ITEMS = 725;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int INDEX_SPAN   = 1 << INDEX_W;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_command    = CMD_ALLOC;
   logic [BYTES_W-1:0]  req_byte_count = '0;
   logic [INDEX_W-1:0]  req_page_index = '0;
   logic                req_free_value = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic                rsp_status;
   logic [BYTES_W-1:0]  rsp_start_address;
   logic [TAKEN_W-1:0]  rsp_pages_taken;

   int mismatches;
   int pending;
   int runs_granted;
   int issued      = 0;
   int alloc_sent  = 0;
   int write_sent  = 0;
   int rsp_taken   = 0;
   bit send_steady = 1'b0;
   bit take_steady = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   contiguous_page_run_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_byte_count    (req_byte_count),
      .req_page_index    (req_page_index),
      .req_free_value    (req_free_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_start_address (rsp_start_address),
      .rsp_pages_taken   (rsp_pages_taken)
   );

   page_run_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_byte_count    (req_byte_count),
      .req_page_index    (req_page_index),
      .req_free_value    (req_free_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_start_address (rsp_start_address),
      .rsp_pages_taken   (rsp_pages_taken),
      .mismatches        (mismatches),
      .pending           (pending),
      .runs_granted      (runs_granted)
   );

   task automatic send_request(input logic                cmd,
                               input logic [BYTES_W-1:0]  bytes,
                               input logic [INDEX_W-1:0]  idx,
                               input logic                fv);
      int gap;
      if (issued % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
      gap = send_steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_byte_count <= bytes;
      req_page_index <= idx;
      req_free_value <= fv;
      do @(posedge clock); while (!req_ready);
      issued++;
      if (cmd == CMD_ALLOC) alloc_sent++;
      else write_sent++;
   endtask

   task automatic allocate(input logic [BYTES_W-1:0] bytes);
      send_request(CMD_ALLOC, bytes, INDEX_W'($urandom), 1'($urandom));
   endtask

   task automatic write_page(input int page, input logic fv);
      send_request(CMD_WRITE, BYTES_W'($urandom), INDEX_W'(page), fv);
   endtask

   // mostly small runs, some spanning regions, a few too big or odd sizes
   function automatic logic [BYTES_W-1:0] random_alloc_bytes();
      int sel;
      int pages;
      sel = $urandom_range(0, 19);
      if (sel == 19) return ($urandom_range(0, 1) == 0) ? '0 : BYTES_W'($urandom);
      if (sel < 11) pages = $urandom_range(1, 16);
      else if (sel < 17) pages = $urandom_range(17, 400);
      else pages = $urandom_range(401, TOTAL_PAGES + 8);
      return BYTES_W'((pages - 1) << PAGE_SHIFT) +
             BYTES_W'($urandom_range(1, 1 << PAGE_SHIFT));
   endfunction

   initial begin : response_side
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_taken % 40 == 0) take_steady = ($urandom_range(0, 3) == 0);
         gap = take_steady ? 0 : $urandom_range(0, 4);
         // long hold-offs so the block backs up into its request side
         if (rsp_taken == 50 || rsp_taken == 400) gap = HOLD_CYCLES;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_taken++;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no request or response moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : request_side
      int start_count;
      int pick;
      int base;
      int len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // rounding, region crossing and reuse of freed pages on a fresh map
      allocate(BYTES_W'(1));
      allocate(BYTES_W'(1) << PAGE_SHIFT);
      allocate((BYTES_W'(1) << PAGE_SHIFT) + 1);
      allocate(BYTES_W'(ENTRIES) << PAGE_SHIFT);
      write_page(0, 1'b1);
      write_page(1, 1'b0);
      allocate(BYTES_W'(1));
      write_page(2, 1'b1);
      write_page(3, 1'b1);
      allocate(BYTES_W'(2) << PAGE_SHIFT);
      write_page(ENTRIES, 1'b1);
      write_page(ENTRIES + 1, 1'b1);
      allocate(BYTES_W'(2) << PAGE_SHIFT);

      start_count = issued;
      while (issued - start_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            allocate(random_alloc_bytes());
         end else if (pick < 85) begin
            // release a run of pages
            base = $urandom_range(0, TOTAL_PAGES - 1);
            len  = $urandom_range(1, 24);
            for (int k = 0; k < len && base + k < TOTAL_PAGES; k++) begin
               write_page(base + k, 1'b1);
            end
         end else if ($urandom_range(0, 3) == 0) begin
            write_page($urandom_range(0, INDEX_SPAN - 1), 1'($urandom));
         end else begin
            write_page($urandom_range(0, TOTAL_PAGES - 1), 1'($urandom));
         end
      end

      // extremes on a fragmented map
      allocate('0);
      allocate(BYTES_W'(TOTAL_PAGES) << PAGE_SHIFT);
      allocate(BYTES_W'(1));
      write_page(TOTAL_PAGES - 1, 1'b1);
      write_page(TOTAL_PAGES, 1'b1);
      write_page(INDEX_SPAN - 1, 1'b0);
      allocate(BYTES_W'(1) << PAGE_SHIFT);
      allocate('1);
      allocate(BYTES_W'(TOTAL_PAGES + 1) << PAGE_SHIFT);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests: %0d allocates with %0d runs granted, %0d bit writes",
               issued, alloc_sent, runs_granted, write_sent);
      $display("including region-crossing runs, oversize and out-of-range requests");
      $display("and two long response stalls");
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[contiguous_page_run_allocator.f]
rtl/core/cpra_pkg.sv
rtl/core/cpra_map_ram.sv
rtl/core/cpra_engine.sv
rtl/core/contiguous_page_run_allocator.sv
tb/sv/page_run_checker.sv
tb/sv/tb_contiguous_page_run_allocator.sv
